// ----- hw/rtl/q2e_pkg.sv -----
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, widths and the arctangent table for the quaternion to
// ZYX Euler angle unit.
// ----------------------------------------------------------------------------
package q2e_pkg;

	localparam int ANGLE_WIDTH_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int QUAT_W      = 16;
	localparam int PROD_W      = 2 * QUAT_W;
	localparam int TERM_W      = 34;
	localparam int ABS_W       = TERM_W - 1;
	localparam int SQ_IN_W     = 30;
	localparam int REST_W      = 61;
	localparam int SQRT_STAGES = 31;
	localparam int VAL_W       = 2 * SQRT_STAGES;
	localparam int ROOT_W      = SQRT_STAGES;
	localparam int REM_W       = ROOT_W + 4;
	localparam int CORD_W      = 38;
	localparam int ZW          = 32;
	localparam int LANES       = 3;

	localparam int LANE_ROLL  = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_YAW   = 2;

	localparam logic signed [TERM_W-1:0] ONE_Q30  = 34'sd1073741824;
	localparam logic [REST_W-1:0]        REST_ONE = REST_W'(1) << 60;
	localparam logic [ZW-1:0]            HALF_TURN    = 32'h8000_0000;
	localparam logic [ZW-1:0]            QUARTER_TURN = 32'h4000_0000;

	typedef logic signed [TERM_W-1:0] term_t;

	typedef struct packed {
		term_t sr;
		term_t cr;
		term_t sp;
		term_t sy;
		term_t cy;
		logic  clamp;
	} terms_t;

	typedef struct packed {
		logic clamp;
		logic sp_neg;
	} pctl_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [ZW-1:0] atan_turn(input int idx);
		case (idx)
			0:  return 32'd536870912;
			1:  return 32'd316933406;
			2:  return 32'd167458907;
			3:  return 32'd85004756;
			4:  return 32'd42667331;
			5:  return 32'd21354465;
			6:  return 32'd10680350;
			7:  return 32'd5340245;
			8:  return 32'd2670163;
			9:  return 32'd1335087;
			10: return 32'd667544;
			11: return 32'd333772;
			12: return 32'd166886;
			13: return 32'd83443;
			14: return 32'd41722;
			15: return 32'd20861;
			16: return 32'd10430;
			17: return 32'd5215;
			18: return 32'd2608;
			19: return 32'd1304;
			20: return 32'd652;
			21: return 32'd326;
			22: return 32'd163;
			23: return 32'd81;
			24: return 32'd41;
			25: return 32'd20;
			26: return 32'd10;
			27: return 32'd5;
			28: return 32'd3;
			29: return 32'd1;
			30: return 32'd1;
			default: return '0;
		endcase
	endfunction

endpackage

// ----- hw/rtl/quaternion_to_euler_zyx_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx_unit
// Unit quaternion in Q1.15 to roll, pitch and yaw (ZYX) as binary angles.
//
//   channel  direction  handshake             payload
//   quat     in         quat_valid/quat_stall  quat_w, quat_x, quat_y, quat_z
//   euler    out        euler_valid/euler_stall roll_angle, pitch_angle,
//                                              yaw_angle, pitch_clamped
//
// one quaternion per cycle unless the output stalls; three term stages,
// 31 square root stages (one root bit each), a fold stage plus one
// stage per CORDIC iteration, and the output register
// reset clears only the valid bits of every stage
// a stall holds only the stages that are full; empty stages keep filling
// ----------------------------------------------------------------------------
module quaternion_to_euler_zyx_unit #(
	parameter int ANGLE_WIDTH  = q2e_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               quat_valid,
	output logic                               quat_stall,
	input  logic signed [q2e_pkg::QUAT_W-1:0]  quat_w,
	input  logic signed [q2e_pkg::QUAT_W-1:0]  quat_x,
	input  logic signed [q2e_pkg::QUAT_W-1:0]  quat_y,
	input  logic signed [q2e_pkg::QUAT_W-1:0]  quat_z,
	output logic                               euler_valid,
	input  logic                               euler_stall,
	output logic signed [ANGLE_WIDTH-1:0]      roll_angle,
	output logic signed [ANGLE_WIDTH-1:0]      pitch_angle,
	output logic signed [ANGLE_WIDTH-1:0]      yaw_angle,
	output logic                               pitch_clamped
);
	import q2e_pkg::*;

	localparam logic [ZW-1:0] RND = (ZW'(1) << (ZW - ANGLE_WIDTH)) >> 1;
	localparam logic [ANGLE_WIDTH-1:0] QA_POS = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
	localparam logic [ANGLE_WIDTH-1:0] QA_NEG = -QA_POS;

	logic              terms_ready, terms_valid;
	terms_t            terms_t1;
	logic [REST_W-1:0] rest;

	logic              sqrt_valid, sqrt_ready;
	logic [ROOT_W-1:0] root;
	terms_t            terms_t2;

	logic                     cor_valid, cor_ready, cor_in_ready;
	logic signed [CORD_W-1:0] cor_y [LANES];
	logic signed [CORD_W-1:0] cor_x [LANES];
	pctl_t                    cor_pctl_in, cor_pctl;
	logic [ZW-1:0]            cor_z [LANES];
	logic [LANES-1:0]         cor_zero;

	logic [ZW-1:0] zsel [LANES];
	logic [ZW-1:0] zrnd [LANES];

	logic                   valid_q;
	logic [ANGLE_WIDTH-1:0] roll_q, pitch_q, yaw_q;
	logic                   clamp_q;

	q2e_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (quat_valid),
		.in_ready  (terms_ready),
		.w         (quat_w),
		.x         (quat_x),
		.y         (quat_y),
		.z         (quat_z),
		.out_valid (terms_valid),
		.out_ready (sqrt_ready),
		.terms     (terms_t1),
		.rest      (rest)
	);

	q2e_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (terms_valid),
		.in_ready  (sqrt_ready),
		.rest      (rest),
		.terms_in  (terms_t1),
		.out_valid (sqrt_valid),
		.out_ready (cor_in_ready),
		.root      (root),
		.terms_out (terms_t2)
	);

	assign cor_y[LANE_ROLL]   = CORD_W'(terms_t2.sr);
	assign cor_x[LANE_ROLL]   = CORD_W'(terms_t2.cr);
	assign cor_y[LANE_PITCH]  = CORD_W'(terms_t2.sp);
	assign cor_x[LANE_PITCH]  = signed'(CORD_W'(root));
	assign cor_y[LANE_YAW]    = CORD_W'(terms_t2.sy);
	assign cor_x[LANE_YAW]    = CORD_W'(terms_t2.cy);
	assign cor_pctl_in.clamp  = terms_t2.clamp;
	assign cor_pctl_in.sp_neg = terms_t2.sp[TERM_W-1];

	q2e_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sqrt_valid),
		.in_ready  (cor_in_ready),
		.in_y      (cor_y),
		.in_x      (cor_x),
		.in_pctl   (cor_pctl_in),
		.out_valid (cor_valid),
		.out_ready (cor_ready),
		.out_z     (cor_z),
		.out_zero  (cor_zero),
		.out_pctl  (cor_pctl)
	);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			zsel[l] = cor_zero[l] ? '0 : cor_z[l];
		end
		if (cor_pctl.clamp) begin
			zsel[LANE_PITCH] = cor_pctl.sp_neg ? -QUARTER_TURN : QUARTER_TURN;
		end
		for (int l = 0; l < LANES; l++) begin
			zrnd[l] = zsel[l] + RND;
		end
	end

	assign cor_ready  = !valid_q || !euler_stall;
	assign quat_stall = !terms_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cor_ready) begin
			valid_q <= cor_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cor_ready) begin
			roll_q  <= zrnd[LANE_ROLL][ZW-1 -: ANGLE_WIDTH];
			pitch_q <= zrnd[LANE_PITCH][ZW-1 -: ANGLE_WIDTH];
			yaw_q   <= zrnd[LANE_YAW][ZW-1 -: ANGLE_WIDTH];
			clamp_q <= cor_pctl.clamp;
		end
	end

	assign euler_valid   = valid_q;
	assign roll_angle    = signed'(roll_q);
	assign pitch_angle   = signed'(pitch_q);
	assign yaw_angle     = signed'(yaw_q);
	assign pitch_clamped = clamp_q;

`ifndef SYNTHESIS
	a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!euler_valid |-> !quat_stall)
		else $error("input stalled with empty output register");

	a_clamp_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		(euler_valid && pitch_clamped) |->
		(pitch_q == QA_POS || pitch_q == QA_NEG))
		else $error("saturated pitch is not a quarter turn");
`endif

endmodule

// ----- hw/rtl/q2e_terms.sv -----
// ----------------------------------------------------------------------------
// q2e_terms
// Three stages: quaternion products, sine and cosine terms with the pitch
// saturation test, then the cosine-squared remainder for the pitch root.
// ----------------------------------------------------------------------------
module q2e_terms (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [q2e_pkg::QUAT_W-1:0]   w,
	input  logic signed [q2e_pkg::QUAT_W-1:0]   x,
	input  logic signed [q2e_pkg::QUAT_W-1:0]   y,
	input  logic signed [q2e_pkg::QUAT_W-1:0]   z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output q2e_pkg::terms_t                     terms,
	output logic [q2e_pkg::REST_W-1:0]          rest
);
	import q2e_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic ready1, ready2, ready3;

	logic signed [PROD_W-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	terms_t                   terms_s2, terms_c;
	logic [ABS_W-1:0]         asp_s2, asp_c;
	terms_t                   terms_s3;
	logic [REST_W-1:0]        rest_s3;
	term_t                    sp_neg_c;
	logic [2*SQ_IN_W-1:0]     sq_c;

	assign ready3   = !valid_s3 || out_ready;
	assign ready2   = !valid_s2 || ready3;
	assign ready1   = !valid_s1 || ready2;
	assign in_ready = ready1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready1) valid_s1 <= in_valid;
			if (ready2) valid_s2 <= valid_s1;
			if (ready3) valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		terms_c.sr    = (TERM_W'(wx_s1) + TERM_W'(yz_s1)) <<< 1;
		terms_c.cr    = ONE_Q30 - ((TERM_W'(xx_s1) + TERM_W'(yy_s1)) <<< 1);
		terms_c.sp    = (TERM_W'(wy_s1) - TERM_W'(zx_s1)) <<< 1;
		terms_c.sy    = (TERM_W'(wz_s1) + TERM_W'(xy_s1)) <<< 1;
		terms_c.cy    = ONE_Q30 - ((TERM_W'(yy_s1) + TERM_W'(zz_s1)) <<< 1);
		sp_neg_c      = -terms_c.sp;
		asp_c         = terms_c.sp[TERM_W-1] ? sp_neg_c[ABS_W-1:0] : terms_c.sp[ABS_W-1:0];
		terms_c.clamp = (asp_c[ABS_W-1:SQ_IN_W] != '0);
	end

	assign sq_c = asp_s2[SQ_IN_W-1:0] * asp_s2[SQ_IN_W-1:0];

	always_ff @(posedge clk) begin
		if (ready1) begin
			wx_s1 <= w * x;
			yz_s1 <= y * z;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			wy_s1 <= w * y;
			zx_s1 <= z * x;
			wz_s1 <= w * z;
			xy_s1 <= x * y;
			zz_s1 <= z * z;
		end
		if (ready2) begin
			terms_s2 <= terms_c;
			asp_s2   <= asp_c;
		end
		if (ready3) begin
			terms_s3 <= terms_s2;
			rest_s3  <= REST_ONE - REST_W'(sq_c);
		end
	end

	assign out_valid = valid_s3;
	assign terms     = terms_s3;
	assign rest      = rest_s3;

endmodule

// ----- hw/rtl/q2e_isqrt.sv -----
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined floor square root, one root bit per stage, carrying the
// angle terms alongside.
// ----------------------------------------------------------------------------
module q2e_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [q2e_pkg::REST_W-1:0]   rest,
	input  q2e_pkg::terms_t              terms_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [q2e_pkg::ROOT_W-1:0]   root,
	output q2e_pkg::terms_t              terms_out
);
	import q2e_pkg::*;

	logic              valid_s [SQRT_STAGES];
	logic [REM_W-1:0]  rem_s   [SQRT_STAGES];
	logic [ROOT_W-1:0] root_s  [SQRT_STAGES];
	logic [VAL_W-1:0]  val_s   [SQRT_STAGES];
	terms_t            terms_s [SQRT_STAGES];
	logic              ready   [SQRT_STAGES+1];

	assign ready[SQRT_STAGES] = out_ready;
	assign in_ready           = ready[0];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic              v_prev;
		logic [REM_W-1:0]  rem_prev, rem_n, trial;
		logic [ROOT_W-1:0] root_prev;
		logic [VAL_W-1:0]  val_prev;
		terms_t            terms_prev;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_prev     = in_valid;
			assign rem_prev   = '0;
			assign root_prev  = '0;
			assign val_prev   = VAL_W'(rest);
			assign terms_prev = terms_in;
		end else begin : g_next
			assign v_prev     = valid_s[k-1];
			assign rem_prev   = rem_s[k-1];
			assign root_prev  = root_s[k-1];
			assign val_prev   = val_s[k-1];
			assign terms_prev = terms_s[k-1];
		end

		assign ready[k] = !valid_s[k] || ready[k+1];
		assign rem_n    = {rem_prev[REM_W-3:0], val_prev[VAL_W-1 -: 2]};
		assign trial    = {{(REM_W-ROOT_W-2){1'b0}}, root_prev, 2'b01};
		assign ge       = (rem_n >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (ready[k]) begin
				valid_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (ready[k]) begin
				rem_s[k]   <= ge ? (rem_n - trial) : rem_n;
				root_s[k]  <= {root_prev[ROOT_W-2:0], ge};
				val_s[k]   <= {val_prev[VAL_W-3:0], 2'b00};
				terms_s[k] <= terms_prev;
			end
		end
	end

	assign out_valid = valid_s[SQRT_STAGES-1];
	assign root      = root_s[SQRT_STAGES-1];
	assign terms_out = terms_s[SQRT_STAGES-1];

endmodule

// ----- hw/rtl/q2e_cordic.sv -----
// ----------------------------------------------------------------------------
// q2e_cordic
// Three-lane vectoring CORDIC: a half-plane fold stage, then one
// micro-rotation per stage for roll, pitch and yaw together.
// ----------------------------------------------------------------------------
module q2e_cordic #(
	parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [q2e_pkg::CORD_W-1:0]  in_y [q2e_pkg::LANES],
	input  logic signed [q2e_pkg::CORD_W-1:0]  in_x [q2e_pkg::LANES],
	input  q2e_pkg::pctl_t                     in_pctl,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [q2e_pkg::ZW-1:0]             out_z [q2e_pkg::LANES],
	output logic [q2e_pkg::LANES-1:0]          out_zero,
	output q2e_pkg::pctl_t                     out_pctl
);
	import q2e_pkg::*;

	localparam int NST = CORDIC_STEPS + 1;

	logic                     valid_s [NST];
	logic signed [CORD_W-1:0] x_s     [NST][LANES];
	logic signed [CORD_W-1:0] y_s     [NST][LANES];
	logic [ZW-1:0]            z_s     [NST][LANES];
	logic [LANES-1:0]         zero_s  [NST];
	pctl_t                    pctl_s  [NST];
	logic                     ready   [NST+1];

	assign ready[NST] = out_ready;
	assign in_ready   = ready[0];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic                     v_prev;
		logic [LANES-1:0]         zero_prev, zero_n;
		pctl_t                    pctl_prev;
		logic signed [CORD_W-1:0] x_n [LANES];
		logic signed [CORD_W-1:0] y_n [LANES];
		logic [ZW-1:0]            z_n [LANES];

		assign ready[k] = !valid_s[k] || ready[k+1];

		if (k == 0) begin : g_fold
			assign v_prev    = in_valid;
			assign pctl_prev = in_pctl;
			assign zero_prev = '0;
			for (genvar l = 0; l < LANES; l++) begin : g_lane
				logic neg;
				assign neg       = in_x[l][CORD_W-1];
				assign zero_n[l] = (in_x[l] == '0) && (in_y[l] == '0);
				assign x_n[l]    = neg ? -in_x[l] : in_x[l];
				assign y_n[l]    = neg ? -in_y[l] : in_y[l];
				assign z_n[l]    = neg ? HALF_TURN : '0;
			end
		end else begin : g_rot
			localparam logic [ZW-1:0] ATAN = atan_turn(k - 1);
			assign v_prev    = valid_s[k-1];
			assign pctl_prev = pctl_s[k-1];
			assign zero_prev = zero_s[k-1];
			assign zero_n    = zero_prev;
			for (genvar l = 0; l < LANES; l++) begin : g_lane
				logic signed [CORD_W-1:0] dx, dy;
				logic                     pos;
				assign dx     = y_s[k-1][l] >>> (k - 1);
				assign dy     = x_s[k-1][l] >>> (k - 1);
				assign pos    = !y_s[k-1][l][CORD_W-1];
				assign x_n[l] = pos ? (x_s[k-1][l] + dx) : (x_s[k-1][l] - dx);
				assign y_n[l] = pos ? (y_s[k-1][l] - dy) : (y_s[k-1][l] + dy);
				assign z_n[l] = pos ? (z_s[k-1][l] + ATAN) : (z_s[k-1][l] - ATAN);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (ready[k]) begin
				valid_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (ready[k]) begin
				x_s[k]    <= x_n;
				y_s[k]    <= y_n;
				z_s[k]    <= z_n;
				zero_s[k] <= zero_n;
				pctl_s[k] <= pctl_prev;
			end
		end
	end

	assign out_valid = valid_s[NST-1];
	assign out_z     = z_s[NST-1];
	assign out_zero  = zero_s[NST-1];
	assign out_pctl  = pctl_s[NST-1];

endmodule

// ----- sim/q2e_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_checker
// Watches the quaternion and euler channels of the unit, computes the
// expected roll, pitch and yaw for every accepted request and compares them
// in order with the accepted results.
// ----------------------------------------------------------------------------
module q2e_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               quat_valid,
	input  logic               quat_stall,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic               euler_valid,
	input  logic               euler_stall,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	input  logic               pitch_clamped,
	output int                 fail_count,
	output int                 pending,
	output int                 clamp_seen
);
	import q2e_pkg::*;

	typedef struct packed {
		logic [15:0] roll;
		logic [15:0] pitch;
		logic [15:0] yaw;
		logic        clamp;
	} euler_t;

	euler_t angles_due[$];

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] vector_angle(longint yv, longint xv);
		logic [31:0] acc;
		longint dx, dy;
		acc = '0;
		if (xv == 0 && yv == 0) return '0;
		if (xv < 0) begin
			xv = -xv;
			yv = -yv;
			acc = HALF_TURN;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			dx = shr_floor(yv, i);
			dy = shr_floor(xv, i);
			if (yv >= 0) begin
				xv += dx;
				yv -= dy;
				acc += atan_turn(i);
			end else begin
				xv -= dx;
				yv += dy;
				acc -= atan_turn(i);
			end
		end
		return acc;
	endfunction

	function automatic longint floor_root(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic logic [15:0] round_angle(logic [31:0] a);
		logic [31:0] t;
		t = a + 32'h8000;
		return t[31:16];
	endfunction

	function automatic euler_t euler_of(longint w, longint x, longint y, longint z);
		euler_t e;
		longint sr, cr, sp, sy, cy, asp, one;
		logic [31:0] p;
		one = 64'sd1 << 30;
		sr = 2 * (w * x + y * z);
		cr = one - 2 * (x * x + y * y);
		sp = 2 * (w * y - z * x);
		sy = 2 * (w * z + x * y);
		cy = one - 2 * (y * y + z * z);
		asp = sp < 0 ? -sp : sp;
		e.clamp = asp >= one;
		if (e.clamp) p = sp > 0 ? QUARTER_TURN : 32'd0 - QUARTER_TURN;
		else p = vector_angle(sp, floor_root((64'd1 << 60) - asp * asp));
		e.roll = round_angle(vector_angle(sr, cr));
		e.pitch = round_angle(p);
		e.yaw = round_angle(vector_angle(sy, cy));
		return e;
	endfunction

	assign pending = angles_due.size();

	always @(posedge clk or negedge arst_n) begin
		euler_t e;
		if (!arst_n) begin
			fail_count <= 0;
			clamp_seen <= 0;
		end else begin
			if (quat_valid && !quat_stall)
				angles_due.push_back(euler_of(quat_w, quat_x, quat_y, quat_z));
			if (euler_valid && !euler_stall) begin
				if (angles_due.size() == 0) begin
					$error("result with no request outstanding");
					fail_count <= fail_count + 1;
				end else begin
					e = angles_due.pop_front();
					if (e.clamp) clamp_seen <= clamp_seen + 1;
					if (e.roll !== roll_angle || e.pitch !== pitch_angle ||
							e.yaw !== yaw_angle || e.clamp !== pitch_clamped)
						fail_count <= fail_count + 1;
					if (e.roll !== roll_angle)
						$error("roll_angle expected %0d got %0d", $signed(e.roll), roll_angle);
					if (e.pitch !== pitch_angle)
						$error("pitch_angle expected %0d got %0d", $signed(e.pitch), pitch_angle);
					if (e.yaw !== yaw_angle)
						$error("yaw_angle expected %0d got %0d", $signed(e.yaw), yaw_angle);
					if (e.clamp !== pitch_clamped)
						$error("pitch_clamped expected %0b got %0b", e.clamp, pitch_clamped);
				end
			end
		end
	end
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random quaternions into the euler unit under four
// idle and stall patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	logic               clk, arst_n;
	logic               quat_valid, quat_stall;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic               euler_valid, euler_stall;
	logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
	logic               pitch_clamped;
	int                 fail_count, pending, clamp_seen;
	int                 send_idle, recv_stall, sent, idle_cycles;
	logic               run_done;

	localparam int SETTLE = 80;
	localparam int WATCHDOG = 20000;

	quaternion_to_euler_zyx_unit dut (.*);

	q2e_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern
	always @(posedge clk) euler_stall <= ($urandom_range(99) < recv_stall);

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((quat_valid && !quat_stall) || (euler_valid && !euler_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_quat(int w, int x, int y, int z);
		while ($urandom_range(99) < send_idle) begin
			quat_valid <= 1'b0;
			@(posedge clk);
		end
		quat_valid <= 1'b1;
		quat_w <= 16'(w);
		quat_x <= 16'(x);
		quat_y <= 16'(y);
		quat_z <= 16'(z);
		@(posedge clk);
		while (quat_stall) @(posedge clk);
		sent++;
	endtask

	// random unit-ish quaternion, occasionally near gimbal lock or fully raw
	task automatic send_random();
		real a, b, c, d, n;
		int kind;
		kind = $urandom_range(9);
		if (kind == 0) begin
			send_quat($urandom, $urandom, $urandom, $urandom);
		end else begin
			a = $urandom_range(65535) - 32768.0;
			b = $urandom_range(65535) - 32768.0;
			c = $urandom_range(65535) - 32768.0;
			d = $urandom_range(65535) - 32768.0;
			if (kind <= 2) begin
				c = a + $urandom_range(400) - 200.0;
				d = -b + $urandom_range(400) - 200.0;
			end
			n = $sqrt(a * a + b * b + c * c + d * d);
			if (n < 1.0) n = 1.0;
			send_quat(int'(a / n * 32767.0), int'(b / n * 32767.0),
				int'(c / n * 32767.0), int'(d / n * 32767.0));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		quat_valid = 1'b0;
		quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
		send_idle = 0;
		recv_stall = 0;
		sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: identity, extremes, half turns, gimbal lock, zero vector
		send_quat(16'sh7fff, 0, 0, 0);
		send_quat(16'sh8000, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(0, 16'sh7fff, 0, 0);
		send_quat(0, 0, 16'sh7fff, 0);
		send_quat(0, 0, 0, 16'sh7fff);
		send_quat(0, 16'sh8000, 0, 0);
		send_quat(0, 0, 0, 16'sh8000);
		send_quat(23170, 0, 23170, 0);
		send_quat(23170, 0, -23170, 0);
		send_quat(23170, 23170, 23170, -23170);
		send_quat(16384, 16384, 16384, 16384);
		send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send_quat(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
		send_quat(23170, 23170, 0, 0);
		send_quat(0, 0, 23170, 23170);
		send_quat(1, -1, 1, -1);
		send_quat(-23170, 0, 23170, 0);
		for (int phase = 0; phase < 4; phase++) begin
			send_idle = (phase == 1 || phase == 3) ? (phase == 3 ? 14 : 87) : 0;
			recv_stall = (phase == 2 || phase == 3) ? (phase == 3 ? 14 : 87) : 0;
			for (int i = 0; i < 100; i++) send_random();
		end
		quat_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d quaternions across four idle/stall patterns", sent);
		$display("%0d of them saturated pitch", clamp_seen);
		if (fail_count == 0 && pending == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ----- filelist.f -----
hw/rtl/q2e_pkg.sv
hw/rtl/q2e_terms.sv
hw/rtl/q2e_isqrt.sv
hw/rtl/q2e_cordic.sv
hw/rtl/quaternion_to_euler_zyx_unit.sv
sim/q2e_checker.sv
sim/testbench.sv
